@@ rtl/core/asp_pkg.sv @@
// ----------------------------------------------------------------------------
// asp_pkg
// Shared types and constants of the A* shortest-path block.
// ----------------------------------------------------------------------------
package asp_pkg;

  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_MAX_EDGES = 256;

  localparam int COST_W = 22;
  localparam int EST_W  = 23;
  localparam int H_W    = 17;
  localparam int SQ_W   = 35;

  localparam logic [COST_W-1:0] COST_MAX = 22'h3FFFFF;

  localparam logic [1:0] MODE_NODE   = 2'd0;
  localparam logic [1:0] MODE_EDGE   = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } pos_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] cnt;
  } range_t;

  typedef struct packed {
    logic [5:0]  tgt;
    logic [15:0] cost;
  } edge_rec_t;

endpackage

@@ rtl/core/asp_graph_store.sv @@
// ----------------------------------------------------------------------------
// asp_graph_store
// Node position, node edge range and edge table memories, registered reads.
// ----------------------------------------------------------------------------
module asp_graph_store import asp_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES,
  localparam int NW = $clog2(MAX_NODES),
  localparam int EW = $clog2(MAX_EDGES)
) (
  input  logic          clk,
  input  logic          node_we,
  input  logic [NW-1:0] node_waddr,
  input  pos_t          pos_wdata,
  input  range_t        rng_wdata,
  input  logic          edge_we,
  input  logic [EW-1:0] edge_waddr,
  input  edge_rec_t     edge_wdata,
  input  logic [NW-1:0] node_raddr,
  output pos_t          pos_rdata,
  output range_t        rng_rdata,
  input  logic [EW-1:0] edge_raddr,
  output edge_rec_t     edge_rdata
);

  pos_t      pos_mem  [MAX_NODES];
  range_t    rng_mem  [MAX_NODES];
  edge_rec_t edge_mem [MAX_EDGES];

  // node records: write on load, read by address
  always_ff @(posedge clk) begin
    if (node_we) begin
      pos_mem[node_waddr] <= pos_wdata;
      rng_mem[node_waddr] <= rng_wdata;
    end
    pos_rdata <= pos_mem[node_raddr];
    rng_rdata <= rng_mem[node_raddr];
  end

  // edge table
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_rdata <= edge_mem[edge_raddr];
  end

endmodule

@@ rtl/core/asp_heur.sv @@
// ----------------------------------------------------------------------------
// asp_heur
// Integer Euclidean distance: one squared axis per cycle, then a
// bit-pair square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module asp_heur import asp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  pos_t           pa,
  input  pos_t           pb,
  output logic           done,
  output logic [H_W-1:0] h
);

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_SQ   = 4'b0010,
    H_LD   = 4'b0100,
    H_RT   = 4'b1000
  } hstate_t;

  hstate_t            state;
  pos_t               a;
  pos_t               b;
  logic [1:0]         dim;
  logic [33:0]        prod;
  logic [SQ_W-1:0]    acc;
  logic [SQ_W-1:0]    rem;
  logic [SQ_W-1:0]    root;
  logic [4:0]         bitpos;
  logic signed [15:0] ca;
  logic signed [15:0] cb;
  logic signed [16:0] d;
  logic [16:0]        ad;
  logic [SQ_W-1:0]    bitv;
  logic [SQ_W-1:0]    trial;
  logic               take;
  logic [SQ_W-1:0]    root_next;

  // pick the axis and form its absolute difference
  always_comb begin
    case (dim)
      2'd0:    begin ca = a.x; cb = b.x; end
      2'd1:    begin ca = a.y; cb = b.y; end
      default: begin ca = a.z; cb = b.z; end
    endcase
    d  = 17'(signed'(ca)) - 17'(signed'(cb));
    ad = d[16] ? 17'(-d) : 17'(d);
  end

  // one square root digit
  always_comb begin
    bitv      = SQ_W'(1) << {bitpos, 1'b0};
    trial     = root + bitv;
    take      = rem >= trial;
    root_next = take ? ((root >> 1) + bitv) : (root >> 1);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= H_IDLE;
    end else begin
      case (state)
        H_IDLE: begin
          if (start) begin
            a     <= pa;
            b     <= pb;
            dim   <= 2'd0;
            acc   <= '0;
            prod  <= '0;
            state <= H_SQ;
          end
        end
        H_SQ: begin
          // square this axis, accumulate the previous one
          prod <= ad * ad;
          acc  <= acc + SQ_W'(prod);
          dim  <= dim + 2'd1;
          if (dim == 2'd3) begin
            state <= H_LD;
          end
        end
        H_LD: begin
          rem    <= acc;
          root   <= '0;
          bitpos <= 5'd16;
          state  <= H_RT;
        end
        H_RT: begin
          if (take) begin
            rem <= rem - trial;
          end
          root   <= root_next;
          bitpos <= bitpos - 5'd1;
          if (bitpos == 5'd0) begin
            h     <= root_next[H_W-1:0];
            done  <= 1'b1;
            state <= H_IDLE;
          end
        end
        default: state <= H_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/astar_shortest_path.sv @@
// ----------------------------------------------------------------------------
// astar_shortest_path
// A* search over a stored graph held in node and edge memories of MAX_NODES and MAX_EDGES entries.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): mode 0 writes a node record, mode 1
// writes an edge slot, both in the cycle of the transfer; mode 2 starts a
// search from node_index to goal_node. Mode 3 is dropped.
// Output channel (out_valid / out_stall): a search returns its path from
// start to goal, one node per transfer with its cost; last marks the end.
// An unreachable goal gives a single transfer with found low.
// Loads are written at their transfer and leave in_stall low. A search holds
// in_stall high until its last result is registered: each open-set pick is a
// scan of the estimate memory; each edge is read and checked, and a relaxed
// neighbor also runs the distance unit; the path then leaves one node at a
// time from the path memory.
// A stalled result holds in the output register and the search waits.
// Reset clears control only; graph memories are undefined until written,
// and search stores need no clearing pass (status flops clear per search).
// ----------------------------------------------------------------------------
module astar_shortest_path import asp_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [5:0]  node_index,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic [7:0]  edge_first,
  input  logic [7:0]  edge_count,
  input  logic [7:0]  edge_slot,
  input  logic [5:0]  edge_target,
  input  logic [15:0] edge_cost,
  input  logic [5:0]  goal_node,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  path_node,
  output logic [21:0] path_cost,
  output logic        found,
  output logic        last
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int EW = $clog2(MAX_EDGES);

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_INIT    = 18'h00002,
    S_GOAL    = 18'h00004,
    S_SCAN    = 18'h00008,
    S_SCANEND = 18'h00010,
    S_PICK    = 18'h00020,
    S_RNG     = 18'h00040,
    S_RNGLAT  = 18'h00080,
    S_EDGE    = 18'h00100,
    S_EDGELAT = 18'h00200,
    S_RELAX   = 18'h00400,
    S_HEUR    = 18'h00800,
    S_TRACE   = 18'h01000,
    S_TRACEW  = 18'h02000,
    S_EMITRD  = 18'h04000,
    S_EMITB   = 18'h08000,
    S_EMITO   = 18'h10000,
    S_ONE     = 18'h20000
  } state_t;

  state_t state;

  // search memories
  logic [COST_W-1:0] best_mem [MAX_NODES];
  logic [EST_W-1:0]  est_mem  [MAX_NODES];
  logic [NW-1:0]     pred_mem [MAX_NODES];
  logic [NW-1:0]     path_mem [MAX_NODES];

  logic [MAX_NODES-1:0] st_open;
  logic [MAX_NODES-1:0] st_closed;

  logic [NW-1:0]     start_n;
  logic [NW-1:0]     goal_n;
  pos_t              goal_pos;
  logic [NW-1:0]     scan_addr;
  logic [NW-1:0]     scan_pidx;
  logic              scan_pend;
  logic              scan_have;
  logic [EST_W-1:0]  scan_best;
  logic [NW-1:0]     cur;
  logic [7:0]        efirst;
  logic [7:0]        ecnt;
  logic [7:0]        k;
  logic [COST_W-1:0] gcur;
  logic [NW-1:0]     nb;
  logic [15:0]       ecost;
  logic [COST_W-1:0] g_reg;
  logic [NW-1:0]     trace_node;
  logic [NW:0]       len;
  logic [NW-1:0]     j;
  logic [NW-1:0]     emit_node;
  logic [5:0]        res_node;
  logic              res_found;

  // memory ports
  logic              srch_we;
  logic [NW-1:0]     srch_waddr;
  logic [COST_W-1:0] best_wdata;
  logic [EST_W-1:0]  est_wdata;
  logic [NW-1:0]     pred_wdata;
  logic [NW-1:0]     best_raddr;
  logic [COST_W-1:0] best_rd;
  logic [EST_W-1:0]  est_rd;
  logic [NW-1:0]     pred_rd;
  logic [NW-1:0]     path_rd;
  logic              path_we;

  // graph store ports
  logic          node_we;
  logic          edge_we;
  logic [NW-1:0] node_raddr;
  logic [EW-1:0] edge_raddr;
  pos_t          pos_wdata;
  range_t        rng_wdata;
  edge_rec_t     edge_wdata;
  pos_t          pos_rd;
  range_t        rng_rd;
  edge_rec_t     edge_rd;
  logic [12:0]   wslot_ext;
  logic [12:0]   slot_ext;
  logic [8:0]    slot;

  // search helpers
  logic              accept;
  logic              out_free;
  logic              start_ok;
  logic              goal_ok;
  logic              tgt_ok;
  logic [COST_W:0]   g_sum;
  logic [COST_W-1:0] g_new;
  logic [NW:0]       len_n;
  logic              heur_start;
  logic              heur_done;
  logic [H_W-1:0]    heur_h;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign start_ok  = {1'b0, node_index} < 7'(MAX_NODES);
  assign goal_ok   = {1'b0, goal_node} < 7'(MAX_NODES);
  assign wslot_ext = {5'b0, edge_slot};
  assign slot      = {1'b0, efirst} + {1'b0, k};
  assign slot_ext  = {4'b0, slot};
  assign tgt_ok    = {1'b0, edge_rd.tgt} < 7'(MAX_NODES);
  assign g_sum     = {1'b0, gcur} + (COST_W + 1)'(ecost);
  assign g_new     = (g_sum > {1'b0, COST_MAX}) ? COST_MAX : g_sum[COST_W-1:0];
  assign len_n     = len + (NW + 1)'(1);

  // graph loads happen at the transfer
  assign node_we    = accept && (mode == MODE_NODE) && start_ok;
  assign edge_we    = accept && (mode == MODE_EDGE) && (wslot_ext < 13'(MAX_EDGES));
  assign pos_wdata  = '{z: pos_z, y: pos_y, x: pos_x};
  assign rng_wdata  = '{first: edge_first, cnt: edge_count};
  assign edge_wdata = '{tgt: edge_target, cost: edge_cost};
  assign edge_raddr = slot_ext[EW-1:0];

  always_comb begin
    case (state)
      S_INIT:    node_raddr = goal_n;
      S_EDGELAT: node_raddr = edge_rd.tgt[NW-1:0];
      default:   node_raddr = cur;
    endcase
  end

  // search memory port control
  always_comb begin
    srch_we    = 1'b0;
    srch_waddr = nb;
    best_wdata = g_reg;
    est_wdata  = EST_W'(g_reg) + EST_W'(heur_h);
    pred_wdata = cur;
    if (state == S_INIT) begin
      srch_we    = 1'b1;
      srch_waddr = start_n;
      best_wdata = '0;
      est_wdata  = '0;
      pred_wdata = start_n;
    end else if (state == S_HEUR && heur_done) begin
      srch_we = 1'b1;
    end
    case (state)
      S_EDGELAT: best_raddr = edge_rd.tgt[NW-1:0];
      S_EMITB:   best_raddr = path_rd;
      S_EMITO:   best_raddr = emit_node;
      default:   best_raddr = cur;
    endcase
    path_we    = (state == S_TRACE);
    heur_start = (state == S_RELAX) && !(st_open[nb] && g_new >= best_rd);
  end

  always_ff @(posedge clk) begin
    if (srch_we) begin
      best_mem[srch_waddr] <= best_wdata;
      est_mem[srch_waddr]  <= est_wdata;
      pred_mem[srch_waddr] <= pred_wdata;
    end
    best_rd <= best_mem[best_raddr];
    est_rd  <= est_mem[scan_addr];
    pred_rd <= pred_mem[trace_node];
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[len[NW-1:0]] <= trace_node;
    end
    path_rd <= path_mem[j];
  end

  asp_graph_store #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_store (
    .clk        (clk),
    .node_we    (node_we),
    .node_waddr (node_index[NW-1:0]),
    .pos_wdata  (pos_wdata),
    .rng_wdata  (rng_wdata),
    .edge_we    (edge_we),
    .edge_waddr (wslot_ext[EW-1:0]),
    .edge_wdata (edge_wdata),
    .node_raddr (node_raddr),
    .pos_rdata  (pos_rd),
    .rng_rdata  (rng_rd),
    .edge_raddr (edge_raddr),
    .edge_rdata (edge_rd)
  );

  asp_heur u_heur (
    .clk   (clk),
    .rst   (rst),
    .start (heur_start),
    .pa    (pos_rd),
    .pb    (goal_pos),
    .done  (heur_done),
    .h     (heur_h)
  );

  // open-set scan: compare the entry read last cycle, lowest index wins ties
  always_ff @(posedge clk) begin
    if (scan_pend && st_open[scan_pidx] && (!scan_have || est_rd < scan_best)) begin
      scan_have <= 1'b1;
      scan_best <= est_rd;
      cur       <= scan_pidx;
    end
    scan_pend <= (state == S_SCAN);
    scan_pidx <= scan_addr;
    if (state == S_GOAL || (state == S_EDGE && k == ecnt)) begin
      scan_have <= 1'b0;
    end
  end

  // search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // release the output register on transfer
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && mode == MODE_SEARCH) begin
            st_open   <= '0;
            st_closed <= '0;
            start_n   <= node_index[NW-1:0];
            goal_n    <= goal_node[NW-1:0];
            if (!start_ok || !goal_ok) begin
              res_node  <= '0;
              res_found <= 1'b0;
              state     <= S_ONE;
            end else if (node_index == goal_node) begin
              res_node  <= node_index;
              res_found <= 1'b1;
              state     <= S_ONE;
            end else begin
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          st_open[start_n] <= 1'b1;
          state            <= S_GOAL;
        end
        S_GOAL: begin
          goal_pos  <= pos_rd;
          scan_addr <= '0;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          if (32'(scan_addr) == MAX_NODES - 1) begin
            state <= S_SCANEND;
          end else begin
            scan_addr <= scan_addr + NW'(1);
          end
        end
        S_SCANEND: state <= S_PICK;
        S_PICK: begin
          if (!scan_have) begin
            res_node  <= '0;
            res_found <= 1'b0;
            state     <= S_ONE;
          end else begin
            st_open[cur]   <= 1'b0;
            st_closed[cur] <= 1'b1;
            if (cur == goal_n) begin
              trace_node <= goal_n;
              len        <= '0;
              state      <= S_TRACE;
            end else begin
              state <= S_RNG;
            end
          end
        end
        S_RNG: state <= S_RNGLAT;
        S_RNGLAT: begin
          efirst <= rng_rd.first;
          ecnt   <= rng_rd.cnt;
          gcur   <= best_rd;
          k      <= '0;
          state  <= S_EDGE;
        end
        S_EDGE: begin
          if (k == ecnt) begin
            scan_addr <= '0;
            state     <= S_SCAN;
          end else if (slot_ext >= 13'(MAX_EDGES)) begin
            k <= k + 8'd1;
          end else begin
            state <= S_EDGELAT;
          end
        end
        S_EDGELAT: begin
          // skip targets beyond the graph and closed nodes
          if (!tgt_ok || st_closed[edge_rd.tgt[NW-1:0]]) begin
            k     <= k + 8'd1;
            state <= S_EDGE;
          end else begin
            nb    <= edge_rd.tgt[NW-1:0];
            ecost <= edge_rd.cost;
            state <= S_RELAX;
          end
        end
        S_RELAX: begin
          if (heur_start) begin
            g_reg <= g_new;
            state <= S_HEUR;
          end else begin
            k     <= k + 8'd1;
            state <= S_EDGE;
          end
        end
        S_HEUR: begin
          if (heur_done) begin
            st_open[nb] <= 1'b1;
            k           <= k + 8'd1;
            state       <= S_EDGE;
          end
        end
        S_TRACE: begin
          len <= len_n;
          if (trace_node == start_n || 32'(len_n) == MAX_NODES) begin
            j     <= len[NW-1:0];
            state <= S_EMITRD;
          end else begin
            state <= S_TRACEW;
          end
        end
        S_TRACEW: begin
          trace_node <= pred_rd;
          state      <= S_TRACE;
        end
        S_EMITRD: state <= S_EMITB;
        S_EMITB: begin
          emit_node <= path_rd;
          state     <= S_EMITO;
        end
        S_EMITO: begin
          if (out_free) begin
            out_valid <= 1'b1;
            path_node <= 6'(emit_node);
            path_cost <= best_rd;
            found     <= 1'b1;
            last      <= (j == '0);
            if (j == '0) begin
              state <= S_IDLE;
            end else begin
              j     <= j - NW'(1);
              state <= S_EMITRD;
            end
          end
        end
        S_ONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            path_node <= res_node;
            path_cost <= '0;
            found     <= res_found;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for astar_shortest_path. A small graph of NL nodes and
// NS edge slots is loaded first, and every random write keeps its ranges and
// targets inside it, so that no search reads an unwritten record. A short
// directed set follows, then a random mix of loads and searches. Each
// accepted search is run through an in-bench A* predictor, and every output
// transfer is checked field by field against the oldest expected path entry.
// ----------------------------------------------------------------------------
module tb;
  import asp_pkg::*;

  localparam int NN = DEF_MAX_NODES;
  localparam int NE = DEF_MAX_EDGES;
  localparam int NL = 16;
  localparam int NS = 64;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] ST_UNVISITED = 2'd0;
  localparam logic [1:0] ST_OPEN      = 2'd1;
  localparam logic [1:0] ST_CLOSED    = 2'd2;
  localparam int N_RANDOM = 55;
  localparam int STUCK_LIMIT = 100000;

  typedef struct {
    logic [1:0]  mode;
    logic [5:0]  idx;
    logic [15:0] x, y, z;
    logic [7:0]  first, cnt, slot;
    logic [5:0]  tgt;
    logic [15:0] cost;
    logic [5:0]  goal;
  } cmd_t;

  typedef struct {
    logic [5:0]        node;
    logic [COST_W-1:0] cost;
    logic              found;
    logic              last;
  } hop_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] mode = '0;
  logic [5:0] node_index = '0;
  logic signed [15:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [7:0] edge_first = '0, edge_count = '0, edge_slot = '0;
  logic [5:0] edge_target = '0;
  logic [15:0] edge_cost = '0;
  logic [5:0] goal_node = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [5:0] path_node;
  logic [21:0] path_cost;
  logic found, last;

  astar_shortest_path DUT (.*);

  // Graph copy held by the predictor
  logic signed [15:0] g_pos[NN][3];
  logic [7:0] g_first[NN], g_cnt[NN];
  logic [5:0] g_tgt[NE];
  logic [15:0] g_cost[NE];

  cmd_t pending[$];
  hop_t path_expect[$];
  cmd_t cur;
  int n_total, n_sent, n_searches, n_hops, n_errors, stuck;
  int send_idle, recv_idle;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int unsigned dist_to(int a, int b);
    longint unsigned sum;
    longint d;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      d = longint'(g_pos[a][k]) - longint'(g_pos[b][k]);
      if (d < 0) d = -d;
      sum += longint'(d) * longint'(d);
    end
    return int'(isqrt(sum));
  endfunction

  function automatic void push_hop(int node, int unsigned cost, bit f, bit l);
    hop_t h;
    h.node = node[5:0];
    h.cost = cost[COST_W-1:0];
    h.found = f;
    h.last = l;
    path_expect = {path_expect, h};
  endfunction

  // A* from s to t over the predictor's graph; queue the expected path
  function automatic void plan_path(int s, int t);
    int unsigned g_best[NN], f_est[NN];
    int pred[NN];
    logic [1:0] stat[NN];
    int route[$];
    int pick, slot, nb, n;
    int unsigned gn;
    for (int i = 0; i < NN; i++) begin
      g_best[i] = 0; f_est[i] = 0; pred[i] = 0; stat[i] = ST_UNVISITED;
    end
    if (s == t) begin
      push_hop(s, 0, 1, 1);
      return;
    end
    stat[s] = ST_OPEN;
    pred[s] = s;
    forever begin
      pick = NN;
      for (int i = 0; i < NN; i++)
        if (stat[i] == ST_OPEN && (pick == NN || f_est[i] < f_est[pick])) pick = i;
      if (pick == NN) begin
        push_hop(0, 0, 0, 1);
        return;
      end
      stat[pick] = ST_CLOSED;
      if (pick == t) break;
      for (int k = 0; k < g_cnt[pick]; k++) begin
        slot = g_first[pick] + k;
        if (slot >= NE) continue;
        nb = g_tgt[slot];
        if (stat[nb] == ST_CLOSED) continue;
        gn = g_best[pick] + g_cost[slot];
        if (gn > COST_MAX) gn = COST_MAX;
        if (stat[nb] == ST_OPEN && gn >= g_best[nb]) continue;
        g_best[nb] = gn;
        f_est[nb] = gn + dist_to(nb, t);
        pred[nb] = pick;
        stat[nb] = ST_OPEN;
      end
    end
    n = t;
    route.push_front(n);
    while (n != s && route.size() < NN) begin
      n = pred[n];
      route.push_front(n);
    end
    foreach (route[i])
      push_hop(route[i], g_best[route[i]], 1, i == route.size() - 1);
  endfunction

  // Apply one accepted transfer to the predictor
  function automatic void absorb(cmd_t c);
    case (c.mode)
      MODE_NODE: begin
        g_pos[c.idx][0] = c.x; g_pos[c.idx][1] = c.y; g_pos[c.idx][2] = c.z;
        g_first[c.idx] = c.first; g_cnt[c.idx] = c.cnt;
      end
      MODE_EDGE: begin
        g_tgt[c.slot] = c.tgt; g_cost[c.slot] = c.cost;
      end
      MODE_SEARCH: begin
        n_searches++;
        plan_path(c.idx, c.goal);
      end
      default: ;
    endcase
  endfunction

  // Random payload, every field filled; ranges stay inside the loaded graph
  function automatic cmd_t any_cmd(logic [1:0] m);
    cmd_t c;
    c.mode = m;
    c.idx = 6'($urandom_range(NL - 1));
    c.x = 16'($urandom); c.y = 16'($urandom); c.z = 16'($urandom);
    c.first = 8'($urandom_range(NS - 4));
    c.cnt = 8'($urandom_range(4));
    c.slot = 8'($urandom_range(NS - 1));
    c.tgt = 6'($urandom_range(NL - 1));
    c.cost = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(200));
    c.goal = 6'($urandom_range(NL - 1));
    return c;
  endfunction

  // Append one item to the driver's queue
  function automatic void enqueue(cmd_t c);
    pending = {pending, c};
  endfunction

  function automatic void add_node(int i, int x, int first, int cnt);
    cmd_t c;
    c = any_cmd(MODE_NODE);
    c.idx = 6'(i); c.x = 16'(x); c.y = 16'(x); c.z = 16'(x);
    c.first = 8'(first); c.cnt = 8'(cnt);
    enqueue(c);
  endfunction

  function automatic void add_edge(int slot, int tgt, int cost);
    cmd_t c;
    c = any_cmd(MODE_EDGE);
    c.slot = 8'(slot); c.tgt = 6'(tgt); c.cost = 16'(cost);
    enqueue(c);
  endfunction

  function automatic void add_search(int s, int t);
    cmd_t c;
    c = any_cmd(MODE_SEARCH);
    c.idx = 6'(s); c.goal = 6'(t);
    enqueue(c);
  endfunction

  // Idle rates per phase: sender/receiver 22/45, then 45/22, then none
  always_comb begin
    if (n_sent * 3 < n_total) begin
      send_idle = 22; recv_idle = 45;
    end else if (n_sent * 3 < n_total * 2) begin
      send_idle = 45; recv_idle = 22;
    end else begin
      send_idle = 0; recv_idle = 0;
    end
  end

  // Drive input transfers; predict on each accepted one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        absorb(cur);
        n_sent++;
      end
      if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
        cur = pending.pop_front();
        in_valid <= 1;
        mode <= cur.mode; node_index <= cur.idx;
        pos_x <= cur.x; pos_y <= cur.y; pos_z <= cur.z;
        edge_first <= cur.first; edge_count <= cur.cnt; edge_slot <= cur.slot;
        edge_target <= cur.tgt; edge_cost <= cur.cost; goal_node <= cur.goal;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Check output transfers against the oldest expected hop
  always @(posedge clk) begin
    hop_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_hops++;
        if (path_expect.size() == 0) begin
          $display("%0t: unexpected result node=%0d cost=%0d found=%0b last=%0b",
                   $time, path_node, path_cost, found, last);
          n_errors++;
        end else begin
          e = path_expect.pop_front();
          if (path_node !== e.node || path_cost !== e.cost || found !== e.found ||
              last !== e.last) begin
            $display("%0t: mismatch expected node=%0d cost=%0d found=%0b last=%0b",
                     $time, e.node, e.cost, e.found, e.last);
            $display("%0t:          actual   node=%0d cost=%0d found=%0b last=%0b",
                     $time, path_node, path_cost, found, last);
            n_errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    int base;
    cmd_t c;
    n_sent = 0; n_searches = 0; n_hops = 0; n_errors = 0; stuck = 0;

    // Load the small graph so that every later search reads written entries
    for (int i = 0; i < NL; i++) begin
      c = any_cmd(MODE_NODE);
      c.idx = 6'(i);
      enqueue(c);
    end
    for (int i = 0; i < NS; i++) begin
      c = any_cmd(MODE_EDGE);
      c.slot = 8'(i);
      enqueue(c);
    end

    // Directed: start equals goal, unreachable goal, extreme positions,
    // zero and maximum edge cost, range running past the table, unused mode
    add_search(3, 3);
    add_node(5, 0, 0, 0);
    add_search(5, 9);
    add_node(7, -32768, 100, 1);
    add_node(8, 32767, 101, 1);
    add_edge(100, 8, 65535);
    add_edge(101, 7, 0);
    add_search(7, 8);
    add_search(8, 7);
    add_node(10, 12, 254, 255);
    add_edge(254, 7, 1);
    add_edge(255, 8, 0);
    add_search(10, 8);
    add_search(0, NL - 1);
    add_search(NL - 1, 0);
    enqueue(any_cmd(MODE_UNUSED));

    // Random mix of node writes, edge writes, searches (the most common) and unused mode
    for (int i = 0; i < N_RANDOM; i++) begin
      base = $urandom_range(99);
      if (base < 30) enqueue(any_cmd(MODE_NODE));
      else if (base < 55) enqueue(any_cmd(MODE_EDGE));
      else if (base < 95) enqueue(any_cmd(MODE_SEARCH));
      else enqueue(any_cmd(MODE_UNUSED));
    end
    n_total = pending.size();

    repeat (5) @(posedge clk);
    rst <= 0;

    wait (pending.size() == 0 && !in_valid && path_expect.size() == 0);
    repeat (300) @(posedge clk);

    $display("tb: %0d transfers in, %0d searches, %0d path results checked",
             n_sent, n_searches, n_hops);
    if (n_errors == 0 && path_expect.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/asp_pkg.sv
rtl/core/asp_graph_store.sv
rtl/core/asp_heur.sv
rtl/core/astar_shortest_path.sv
bench/tb.sv
